@@ src/c2s_pkg.sv @@
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants for the Cartesian to spherical / cylindrical converter:
// CORDIC angle table, gain correction factor and fixed-point formats.
// ----------------------------------------------------------------------------
package c2s_pkg;

    // Fraction bits kept on coordinates inside the CORDIC
    localparam int GUARD = 6;

    // Gain correction: 0.607252935 as INV_GAIN / 2^GAIN_W
    localparam int GAIN_W = 22;
    localparam logic [GAIN_W-1:0] INV_GAIN = 22'd2547003;

    // Angle accumulator in units of 2*pi / 2^32, with headroom
    localparam int ANGLE_W = 34;
    localparam int ANG_OUT_W = 16;
    localparam int ANG_SHIFT = 16;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ANGLE_W-1:0] ANG_HALF_LSB = 34'sd32768;

    // Inclination clamp, in output units (pi)
    localparam int INCL_A_W = ANGLE_W - ANG_SHIFT;
    localparam logic signed [INCL_A_W-1:0] INCL_MAX = 18'sd32768;

    localparam int ANGLE_TAB_LEN = 24;
    localparam logic [31:0] ANGLE_TAB [0:ANGLE_TAB_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

@@ src/cartesian_to_spherical_cylindrical_unit.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical_cylindrical_unit
// Converts a signed 3D point to spherical (r, azimuth, inclination) or
// cylindrical (rxy, azimuth, height) coordinates with two CORDIC passes.
// ----------------------------------------------------------------------------
// One point is taken per clock cycle while o_s_tready is high, and one
// result leaves per point, in order. Between the input transaction and
// output valid, each CORDIC pass is a pre-rotation register, one register
// per micro-rotation and two gain-multiply registers, plus a rounding
// register between the passes and the output register. The whole
// pipeline advances together; the output register is backed by a one-entry
// skid buffer, so a held result does not block input until the skid fills,
// and input ready then comes straight from that skid flag. Pass one vectors
// (x, y) to give the azimuth and planar radius; pass two vectors (z, rxy) to
// give the inclination and full radius, used in spherical mode only. Angles
// are binary angles, 32768 standing for pi (azimuth pi reads as -32768).
// Radii are corrected for CORDIC gain, rounded, and saturate at all ones. A
// zero radius sets the flag in tuser and forces the angles to zero.
module cartesian_to_spherical_cylindrical_unit #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // Input stream
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    // tdata: x_coord, y_coord, z_coord (zero-padded to bytes)
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]            i_s_tdata,
    // tuser: mode (0 spherical, 1 cylindrical)
    input  logic                                          i_s_tuser,
    // Output stream
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    // tdata: distance, azimuth, inclination, height (zero-padded to bytes)
    output logic [((2*COORD_WIDTH+2*c2s_pkg::ANG_OUT_W+7)/8)*8-1:0] o_m_tdata,
    // tuser: zero_radius
    output logic                                          o_m_tuser
);
    import c2s_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int DW      = W + GUARD + 4;
    localparam int MAG_W   = DW - 1;
    localparam int PROD_W  = MAG_W + GAIN_W;
    localparam int DSUM_W  = PROD_W - GAIN_W - GUARD;
    localparam int OUT_W   = ((2*W + 2*ANG_OUT_W + 7) / 8) * 8;
    localparam int SIDE1_W = W + 2;
    localparam int SIDE2_W = 2*W + ANG_OUT_W + 2;

    localparam logic [PROD_W-1:0] RND_RXY  = PROD_W'(1) << (GAIN_W - 1);
    localparam logic [PROD_W-1:0] RND_DIST = PROD_W'(1) << (GAIN_W + GUARD - 1);

    // Round gain-corrected product to whole units, saturate to the field
    function automatic logic [W-1:0] f_dist(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        logic [DSUM_W-1:0] d;
        s = p + RND_DIST;
        d = s[PROD_W-1:GAIN_W+GUARD];
        if (d[DSUM_W-1:W] != '0) begin
            return '1;
        end
        return d[W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Flow control: pipeline moves whenever the skid entry is free
    // ------------------------------------------------------------------
    logic r_skid_valid;
    logic r_out_valid;
    logic w_en;

    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    // ------------------------------------------------------------------
    // Pass one: vector (x, y)
    // ------------------------------------------------------------------
    logic signed [W-1:0]  w_x, w_y, w_z;
    logic signed [DW-1:0] w_x1, w_y1;
    logic                 w_xy_zero;
    logic [SIDE1_W-1:0]   w_side1_in, w_side1;
    logic                 w_v1;
    logic signed [ANGLE_W-1:0] w_ang1;
    logic [PROD_W-1:0]    w_prod1;

    assign w_x = signed'(i_s_tdata[W-1:0]);
    assign w_y = signed'(i_s_tdata[2*W-1:W]);
    assign w_z = signed'(i_s_tdata[3*W-1:2*W]);

    assign w_x1 = {{(DW-W-GUARD){w_x[W-1]}}, w_x, {GUARD{1'b0}}};
    assign w_y1 = {{(DW-W-GUARD){w_y[W-1]}}, w_y, {GUARD{1'b0}}};

    assign w_xy_zero  = (w_x == '0) && (w_y == '0);
    assign w_side1_in = {w_xy_zero, w_z, i_s_tuser};

    c2s_vector #(
        .DATA_W (DW),
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (SIDE1_W)
    ) u_pass1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_x     (w_x1),
        .i_y     (w_y1),
        .i_side  (w_side1_in),
        .o_valid (w_v1),
        .o_angle (w_ang1),
        .o_prod  (w_prod1),
        .o_side  (w_side1)
    );

    // ------------------------------------------------------------------
    // Between passes: round planar radius, azimuth, cylindrical distance
    // ------------------------------------------------------------------
    logic                 w_m_mode, w_m_xy_zero;
    logic signed [W-1:0]  w_m_z;
    logic [PROD_W-1:0]    w_rxy_sum;
    logic signed [ANGLE_W-1:0] w_az_sum;

    assign w_m_mode    = w_side1[0];
    assign w_m_z       = signed'(w_side1[W:1]);
    assign w_m_xy_zero = w_side1[W+1];
    assign w_rxy_sum   = w_prod1 + RND_RXY;
    assign w_az_sum    = w_ang1 + ANG_HALF_LSB;

    logic                    r_m_valid;
    logic [MAG_W-1:0]        r_m_rxy;
    logic [W-1:0]            r_m_dist;
    logic [ANG_OUT_W-1:0]    r_m_az;
    logic signed [W-1:0]     r_m_z;
    logic                    r_m_mode;
    logic                    r_m_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_rxy  <= w_rxy_sum[PROD_W-1:GAIN_W];
            r_m_dist <= f_dist(w_prod1);
            // Zero planar point: no meaningful azimuth
            r_m_az   <= w_m_xy_zero ? '0 : w_az_sum[ANG_SHIFT+ANG_OUT_W-1:ANG_SHIFT];
            r_m_z    <= w_m_z;
            r_m_mode <= w_m_mode;
            r_m_zero <= w_m_mode ? w_m_xy_zero : (w_m_xy_zero && (w_m_z == '0));
        end
    end

    // ------------------------------------------------------------------
    // Pass two: vector (z, rxy)
    // ------------------------------------------------------------------
    logic signed [DW-1:0] w_x2, w_y2;
    logic [SIDE2_W-1:0]   w_side2_in, w_side2;
    logic                 w_v2;
    logic signed [ANGLE_W-1:0] w_ang2;
    logic [PROD_W-1:0]    w_prod2;

    assign w_x2       = {{(DW-W-GUARD){r_m_z[W-1]}}, r_m_z, {GUARD{1'b0}}};
    assign w_y2       = signed'({1'b0, r_m_rxy});
    assign w_side2_in = {r_m_zero, r_m_z, r_m_az, r_m_dist, r_m_mode};

    c2s_vector #(
        .DATA_W (DW),
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (SIDE2_W)
    ) u_pass2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m_valid),
        .i_x     (w_x2),
        .i_y     (w_y2),
        .i_side  (w_side2_in),
        .o_valid (w_v2),
        .o_angle (w_ang2),
        .o_prod  (w_prod2),
        .o_side  (w_side2)
    );

    // ------------------------------------------------------------------
    // Result assembly
    // ------------------------------------------------------------------
    logic                      w_f_mode, w_f_zero;
    logic [W-1:0]              w_f_dist1;
    logic [ANG_OUT_W-1:0]      w_f_az;
    logic signed [W-1:0]       w_f_z;
    logic signed [ANGLE_W-1:0] w_inc_sum;
    logic signed [INCL_A_W-1:0] w_inc_a;
    logic [ANG_OUT_W-1:0]      w_incl;
    logic [W-1:0]              w_dist, w_height;
    logic [OUT_W-1:0]          w_res_data;

    assign w_f_mode  = w_side2[0];
    assign w_f_dist1 = w_side2[W:1];
    assign w_f_az    = w_side2[W+ANG_OUT_W:W+1];
    assign w_f_z     = signed'(w_side2[2*W+ANG_OUT_W:W+ANG_OUT_W+1]);
    assign w_f_zero  = w_side2[2*W+ANG_OUT_W+1];
    assign w_inc_sum = w_ang2 + ANG_HALF_LSB;
    assign w_inc_a   = w_inc_sum[ANGLE_W-1:ANG_SHIFT];

    always_comb begin
        // Clamp inclination to 0..pi
        if (w_inc_a[INCL_A_W-1]) begin
            w_incl = '0;
        end else if (w_inc_a > INCL_MAX) begin
            w_incl = INCL_MAX[ANG_OUT_W-1:0];
        end else begin
            w_incl = w_inc_a[ANG_OUT_W-1:0];
        end
        if (w_f_mode) begin
            w_dist   = w_f_dist1;
            w_height = w_f_z;
            w_incl   = '0;
        end else begin
            w_dist   = f_dist(w_prod2);
            w_height = '0;
            if (w_f_zero) begin
                w_incl = '0;
            end
        end
    end

    assign w_res_data = OUT_W'({w_height, w_incl, w_f_az, w_dist});

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] r_out_data, r_skid_data;
    logic             r_out_zero, r_skid_zero;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            // Drain the skid first; else take the pipeline head
            r_out_valid  <= r_skid_valid || w_v2;
            r_skid_valid <= 1'b0;
        end else if (w_v2 && w_en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_res_data;
            r_out_zero <= r_skid_valid ? r_skid_zero : w_f_zero;
        end
        if (!w_out_free && w_en) begin
            r_skid_data <= w_res_data;
            r_skid_zero <= w_f_zero;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_zero;

`ifndef ASSERT_OFF
    // Skid holds data only behind an occupied output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // Skid fills only when the output was held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_tready))
        else $error("skid filled without output stall");

    // Zero radius forces both angles to zero
    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata[W+ANG_OUT_W-1:W] == '0) &&
            (o_m_tdata[W+2*ANG_OUT_W-1:W+ANG_OUT_W] == '0))
        else $error("zero radius with nonzero angle");

    // Inclination stays within 0..pi
    a_incl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            (o_m_tdata[W+2*ANG_OUT_W-1:W+ANG_OUT_W] <= INCL_MAX[ANG_OUT_W-1:0]))
        else $error("inclination out of range");
`endif

endmodule

@@ src/c2s_vector.sv @@
// ----------------------------------------------------------------------------
// c2s_vector
// Pipelined vectoring CORDIC: quadrant pre-rotation, one register stage per
// micro-rotation, then a two-stage split multiply for gain correction.
// ----------------------------------------------------------------------------
module c2s_vector #(
    parameter int DATA_W = 26,
    parameter int STEPS  = 16,
    parameter int SIDE_W = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [DATA_W-1:0]              i_x,
    input  logic signed [DATA_W-1:0]              i_y,
    input  logic [SIDE_W-1:0]                     i_side,
    output logic                                  o_valid,
    output logic signed [c2s_pkg::ANGLE_W-1:0]    o_angle,
    output logic [DATA_W+c2s_pkg::GAIN_W-2:0]     o_prod,
    output logic [SIDE_W-1:0]                     o_side
);
    import c2s_pkg::*;

    localparam int MAG_W  = DATA_W - 1;
    localparam int LO_W   = MAG_W / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PLO_W  = LO_W + GAIN_W;
    localparam int PHI_W  = HI_W + GAIN_W;
    localparam int PROD_W = MAG_W + GAIN_W;

    logic signed [DATA_W-1:0]  r_x   [0:STEPS];
    logic signed [DATA_W-1:0]  r_y   [0:STEPS];
    logic signed [ANGLE_W-1:0] r_acc [0:STEPS];
    logic                      r_v   [0:STEPS];
    logic [SIDE_W-1:0]         r_sd  [0:STEPS];

    logic signed [DATA_W-1:0]  n_x0, n_y0;
    logic signed [ANGLE_W-1:0] n_acc0;

    // Turn left-half-plane vectors by a quarter turn toward the x axis
    always_comb begin
        n_x0   = i_x;
        n_y0   = i_y;
        n_acc0 = '0;
        if (i_x[DATA_W-1]) begin
            if (!i_y[DATA_W-1]) begin
                n_x0   = i_y;
                n_y0   = -i_x;
                n_acc0 = QUARTER_TURN;
            end else begin
                n_x0   = -i_y;
                n_y0   = i_x;
                n_acc0 = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= n_x0;
            r_y[0]   <= n_y0;
            r_acc[0] <= n_acc0;
            r_sd[0]  <= i_side;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic signed [DATA_W-1:0]  n_x, n_y;
        logic signed [ANGLE_W-1:0] n_acc;
        logic signed [ANGLE_W-1:0] w_ang;

        assign w_ang = signed'({2'b00, ANGLE_TAB[g]});

        // Rotate toward y = 0
        always_comb begin
            if (!r_y[g][DATA_W-1]) begin
                n_x   = r_x[g] + (r_y[g] >>> g);
                n_y   = r_y[g] - (r_x[g] >>> g);
                n_acc = r_acc[g] + w_ang;
            end else begin
                n_x   = r_x[g] - (r_y[g] >>> g);
                n_y   = r_y[g] + (r_x[g] >>> g);
                n_acc = r_acc[g] - w_ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g+1]   <= n_x;
                r_y[g+1]   <= n_y;
                r_acc[g+1] <= n_acc;
                r_sd[g+1]  <= r_sd[g];
            end
        end
    end

    // Gain correction: magnitude split in two halves, each multiplied separately
    logic [MAG_W-1:0]          w_mag;
    logic [PLO_W-1:0]          r_plo;
    logic [PHI_W-1:0]          r_phi;
    logic signed [ANGLE_W-1:0] r_acc_a, r_acc_b;
    logic [SIDE_W-1:0]         r_sd_a, r_sd_b;
    logic                      r_v_a, r_v_b;
    logic [PROD_W-1:0]         r_prod;

    assign w_mag = r_x[STEPS][DATA_W-1] ? '0 : r_x[STEPS][MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
        end else if (i_en) begin
            r_v_a <= r_v[STEPS];
            r_v_b <= r_v_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo   <= PLO_W'(w_mag[LO_W-1:0]) * PLO_W'(INV_GAIN);
            r_phi   <= PHI_W'(w_mag[MAG_W-1:LO_W]) * PHI_W'(INV_GAIN);
            r_acc_a <= r_acc[STEPS];
            r_sd_a  <= r_sd[STEPS];
            r_prod  <= (PROD_W'(r_phi) << LO_W) + PROD_W'(r_plo);
            r_acc_b <= r_acc_a;
            r_sd_b  <= r_sd_a;
        end
    end

    assign o_valid = r_v_b;
    assign o_angle = r_acc_b;
    assign o_prod  = r_prod;
    assign o_side  = r_sd_b;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cartesian_to_spherical_cylindrical_unit. A short
// table of directed points is followed by randomized points, sent in bursts
// against a receiver that stalls on its own pattern. A bit-exact CORDIC
// model in the bench predicts each result not typed into the table.
// Results are checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COORD_W = 16;
    localparam int STEPS = 16;
    localparam int IN_W = ((3*COORD_W+7)/8)*8;
    localparam int OUT_W = ((2*COORD_W+2*c2s_pkg::ANG_OUT_W+7)/8)*8;

    // Pipeline depth of the RTL plus margin, for the final drain
    localparam int LATENCY = 2*STEPS + 8;
    localparam int DRAIN_CYCLES = LATENCY + 24;
    localparam int RANDOM_POINTS = 900;
    // Long receiver hold-off: well beyond pipeline depth plus skid entry
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER_RESULTS = 100;

    localparam logic MODE_SPH = 1'b0;
    localparam logic MODE_CYL = 1'b1;

    localparam longint DIST_MAX = (64'sd1 <<< COORD_W) - 1;

    typedef struct packed {
        logic              mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic [COORD_W-1:0] distance;
        logic [15:0]        azimuth;
        logic [15:0]        inclination;
        logic [COORD_W-1:0] height;
        logic               zero_radius;
    } t_coord_result;

    // One row of the directed table; known rows carry a typed-in result
    typedef struct packed {
        t_point        pt;
        logic          known;
        t_coord_result want;
    } t_stim_row;

    typedef enum {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_RARE} t_ready_pattern;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata = '0;   // x_coord, y_coord, z_coord
    logic              i_s_tuser = 1'b0; // mode
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;        // distance, azimuth, inclination, height
    logic              o_m_tuser;        // zero_radius

    t_coord_result expected_coords [$];
    int            mismatches = 0;
    int            results_seen = 0;
    int            burst_left = 0;

    cartesian_to_spherical_cylindrical_unit #(
        .COORD_WIDTH  (COORD_W),
        .CORDIC_STEPS (STEPS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Vectoring CORDIC: rotate (vx, vy) onto the positive x axis. Returns the
    // angle in 2^-32 turns; mag gets the gain-scaled magnitude.
    function automatic longint cordic_vector(input longint vx, input longint vy,
                                             output longint mag);
        longint x, y, acc, t, nx, ny;
        int     n;
        x = vx;
        y = vy;
        acc = 0;
        n = (STEPS > c2s_pkg::ANGLE_TAB_LEN) ? c2s_pkg::ANGLE_TAB_LEN : STEPS;
        // Left half-plane: quarter turn first so the steps can converge
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t;
                acc = longint'(c2s_pkg::QUARTER_TURN);
            end else begin
                t = x; x = -y; y = t;
                acc = -longint'(c2s_pkg::QUARTER_TURN);
            end
        end
        for (int i = 0; i < n; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                acc += longint'(c2s_pkg::ANGLE_TAB[i]);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                acc -= longint'(c2s_pkg::ANGLE_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        mag = x;
        return acc;
    endfunction

    // Gain-corrected radius, rounded half up, keeping 'keep' fraction bits
    function automatic longint gain_correct(input longint mag, input int keep);
        longint full;
        int     sh;
        full = (mag < 0 ? 64'sd0 : mag) * longint'(c2s_pkg::INV_GAIN);
        sh = c2s_pkg::GAIN_W + c2s_pkg::GUARD - keep;
        return (full + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic t_coord_result convert_point(input t_point p);
        longint        x, y, z, scale, az_acc, inc_acc, mag, rxy_g, radius, a;
        t_coord_result r;
        x = $signed(p.x);
        y = $signed(p.y);
        z = $signed(p.z);
        scale = 64'sd1 <<< c2s_pkg::GUARD;
        r = '0;
        rxy_g = 0;
        radius = 0;

        // Pass one: azimuth and planar radius; skipped for a point on the z axis
        if (x != 0 || y != 0) begin
            az_acc = cordic_vector(x * scale, y * scale, mag);
            rxy_g = gain_correct(mag, c2s_pkg::GUARD);
            radius = gain_correct(mag, 0);
            r.azimuth = 16'((az_acc + longint'(c2s_pkg::ANG_HALF_LSB))
                            >>> c2s_pkg::ANG_SHIFT);
        end

        if (p.mode == MODE_CYL) begin
            r.zero_radius = (x == 0 && y == 0);
            r.height = p.z;
        end else if (x == 0 && y == 0 && z == 0) begin
            r.zero_radius = 1'b1;
            radius = 0;
            r.azimuth = '0;
        end else begin
            // Pass two: inclination from (z, rxy), and the full radius
            inc_acc = cordic_vector(z * scale, rxy_g, mag);
            a = (inc_acc + longint'(c2s_pkg::ANG_HALF_LSB)) >>> c2s_pkg::ANG_SHIFT;
            radius = gain_correct(mag, 0);
            if (a < 0) a = 0;
            if (a > longint'(c2s_pkg::INCL_MAX)) a = longint'(c2s_pkg::INCL_MAX);
            r.inclination = 16'(a);
        end

        r.distance = COORD_W'((radius > DIST_MAX) ? DIST_MAX : radius);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_stim_row point_row(input logic m, input int x, input int y,
                                            input int z);
        t_stim_row row;
        row = '0;
        row.pt.mode = m;
        row.pt.x = COORD_W'(x);
        row.pt.y = COORD_W'(y);
        row.pt.z = COORD_W'(z);
        return row;
    endfunction

    function automatic t_stim_row known_row(input logic m, input int x, input int y,
                                            input int z, input int radius, input int az,
                                            input int incl, input int h, input logic zr);
        t_stim_row row;
        row = point_row(m, x, y, z);
        row.known = 1'b1;
        row.want.distance = COORD_W'(radius);
        row.want.azimuth = 16'(az);
        row.want.inclination = 16'(incl);
        row.want.height = COORD_W'(h);
        row.want.zero_radius = zr;
        return row;
    endfunction

    function automatic logic [COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(COORD_W-1){1'b0}}};
            1: return {1'b1, {(COORD_W-2){1'b0}}, 1'b1};
            2: return '1;
            3: return '0;
            4: return COORD_W'(1);
            default: return {1'b0, {(COORD_W-1){1'b1}}};
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] small_coord();
        return COORD_W'(int'($urandom_range(0, 127)) - 64);
    endfunction

    // Mostly uniform points, with a share of small values, points on axes
    // and planes, corners of the range, and the z axis itself
    function automatic t_point random_point();
        t_point p;
        int     pick;
        p.mode = 1'($urandom_range(0, 1));
        p.x = COORD_W'($urandom);
        p.y = COORD_W'($urandom);
        p.z = COORD_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 5) begin
            p.x = small_coord();
            p.y = small_coord();
            p.z = small_coord();
        end else if (pick == 6) begin
            if ($urandom_range(0, 1)) p.x = '0;
            if ($urandom_range(0, 1)) p.y = '0;
            if ($urandom_range(0, 1)) p.z = '0;
        end else if (pick == 7) begin
            p.x = corner_coord();
            p.y = corner_coord();
            p.z = corner_coord();
        end else if (pick == 8) begin
            p.x = '0;
            p.y = '0;
            if ($urandom_range(0, 3) == 0) p.z = '0;
        end else if (pick == 9) begin
            p.z = small_coord();
        end
        return p;
    endfunction

    // Offer one point, hold it until the transaction, queue its expected
    // result, then close the burst with a random gap when it runs out
    task automatic deliver(input t_point p, input logic known, input t_coord_result want);
        i_s_tuser <= p.mode;
        i_s_tdata <= {p.z, p.y, p.x};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_coords.push_back(known ? want : convert_point(p));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: reset, directed table, random points, drain, verdict
    // ------------------------------------------------------------------------
    initial begin
        t_stim_row directed [$];
        t_stim_row row;

        // Zero radius: flag set, angles forced to zero, z passed in cylindrical
        directed.push_back(known_row(MODE_SPH, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        directed.push_back(known_row(MODE_CYL, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        directed.push_back(known_row(MODE_CYL, 0, 0, 32767, 0, 0, 0, 32767, 1'b1));
        directed.push_back(known_row(MODE_CYL, 0, 0, -32768, 0, 0, 0, -32768, 1'b1));
        // On the z axis in spherical mode: pass two only
        directed.push_back(point_row(MODE_SPH, 0, 0, 32767));
        directed.push_back(point_row(MODE_SPH, 0, 0, -32768));
        // Axes and the negative x axis, where the azimuth wraps to -pi
        directed.push_back(point_row(MODE_SPH, 32767, 0, 0));
        directed.push_back(point_row(MODE_SPH, -32768, 0, 0));
        directed.push_back(point_row(MODE_CYL, -32768, 0, 5));
        directed.push_back(point_row(MODE_SPH, 0, 32767, 0));
        directed.push_back(point_row(MODE_SPH, 0, -32768, 0));
        // Largest radii, near the saturation limit
        directed.push_back(point_row(MODE_SPH, 32767, 32767, 32767));
        directed.push_back(point_row(MODE_SPH, -32768, -32768, -32768));
        directed.push_back(point_row(MODE_CYL, -32768, -32768, 0));
        directed.push_back(point_row(MODE_CYL, 32767, -32768, -1));
        // Tiny vectors and both pre-rotation directions
        directed.push_back(point_row(MODE_SPH, -1, -1, -1));
        directed.push_back(point_row(MODE_SPH, 1, 0, 0));
        directed.push_back(point_row(MODE_CYL, -1, 1, 0));
        directed.push_back(point_row(MODE_SPH, -5, -3, 7));
        directed.push_back(point_row(MODE_SPH, -7, 3, -9));
        // Inclination near 3/4 pi, and against both clamp limits
        directed.push_back(point_row(MODE_SPH, 100, 0, -100));
        directed.push_back(point_row(MODE_SPH, 1, 0, -32768));
        directed.push_back(point_row(MODE_SPH, 1, 0, 32767));

        // Hold reset, then release it at a rising edge
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = $urandom_range(0, 40);
        foreach (directed[i]) begin
            row = directed[i];
            deliver(row.pt, row.known, row.want);
        end
        repeat (RANDOM_POINTS) deliver(random_point(), 1'b0, '0);
        i_s_tvalid <= 1'b0;

        // Wait out the pipeline, then give stray results time to show up
        while (expected_coords.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stretches of random ready patterns, plus one long hold-off
    // that backs the pipeline up into the input
    // ------------------------------------------------------------------------
    initial begin
        t_ready_pattern pattern;
        int             stretch;
        bit             held;
        held = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && results_seen >= HOLD_AFTER_RESULTS) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end
            pattern = t_ready_pattern'($urandom_range(0, 3));
            stretch = $urandom_range(10, 120);
            repeat (stretch) begin
                case (pattern)
                    RDY_ALWAYS: i_m_tready <= 1'b1;
                    RDY_HALF:   i_m_tready <= 1'($urandom_range(0, 1));
                    RDY_MOSTLY: i_m_tready <= ($urandom_range(0, 7) != 0);
                    default:    i_m_tready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each output transaction with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_coord_result want;
        t_coord_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.distance = o_m_tdata[COORD_W-1:0];
            got.azimuth = o_m_tdata[COORD_W +: 16];
            got.inclination = o_m_tdata[COORD_W+16 +: 16];
            got.height = o_m_tdata[COORD_W+32 +: COORD_W];
            got.zero_radius = o_m_tuser;
            results_seen++;
            if (expected_coords.size() == 0) begin
                $error("unexpected result transaction: distance %0d azimuth %0d",
                       got.distance, $signed(got.azimuth));
                mismatches++;
            end else begin
                want = expected_coords.pop_front();
                if (got.distance !== want.distance) begin
                    $error("distance mismatch: expected %0d, actual %0d",
                           want.distance, got.distance);
                    mismatches++;
                end
                if (got.azimuth !== want.azimuth) begin
                    $error("azimuth mismatch: expected %0d, actual %0d",
                           $signed(want.azimuth), $signed(got.azimuth));
                    mismatches++;
                end
                if (got.inclination !== want.inclination) begin
                    $error("inclination mismatch: expected %0d, actual %0d",
                           want.inclination, got.inclination);
                    mismatches++;
                end
                if (got.height !== want.height) begin
                    $error("height mismatch: expected %0d, actual %0d",
                           $signed(want.height), $signed(got.height));
                    mismatches++;
                end
                if (got.zero_radius !== want.zero_radius) begin
                    $error("zero_radius mismatch: expected %0d, actual %0d",
                           want.zero_radius, got.zero_radius);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop far beyond the slowest legal run
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ cartesian_to_spherical_cylindrical_unit.f @@
src/c2s_pkg.sv
src/c2s_vector.sv
src/cartesian_to_spherical_cylindrical_unit.sv
tb/testbench.sv
